### hw/rtl/ignore_context_table_assert.svh
// assertion macros for the ignore context table checker
`ifndef IGNORE_CONTEXT_TABLE_ASSERT_SVH
`define IGNORE_CONTEXT_TABLE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define ICT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ict assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define ICT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ict assertion failed");

`endif

### hw/rtl/ict_pkg.sv
// types and constants shared by the ignore context table modules
`timescale 1ns / 1ps

package ict_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 64;
	localparam int OUT_CNT_W = 6;

	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [15:0] net_id;
		logic [15:0] stream_id;
		logic [15:0] service_id;
		logic [15:0] pid;
	} req_t;

	typedef struct packed {
		logic                 hit;
		logic [OUT_CNT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [KEY_W-1:0] wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

endpackage

### hw/rtl/ict_key_mem.sv
// key store: one write port, one registered read port
`timescale 1ns / 1ps

module ict_key_mem (
	input  logic                     clk,
	input  ict_pkg::mem_req_t        mem_req,
	output logic [ict_pkg::KEY_W-1:0] rd_data
);

	logic [ict_pkg::KEY_W-1:0] mem_q [ict_pkg::CAPACITY];
	logic [ict_pkg::KEY_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem_q[mem_req.waddr] <= mem_req.wdata;
		end
		if (mem_req.re) begin
			rd_data_q <= mem_q[mem_req.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/ict_ctrl.sv
// sequencer: scans the key store with one comparator, then inserts an absent key on an add and reports the result
`timescale 1ns / 1ps

module ict_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  ict_pkg::req_t             in_word,
	output logic                      out_valid,
	input  logic                      out_ready,
	output ict_pkg::rsp_t             out_word,
	output ict_pkg::mem_req_t         mem_req,
	input  logic [ict_pkg::KEY_W-1:0] rd_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	state_t                    state_q;
	logic [ict_pkg::KEY_W-1:0] key_q;
	logic                      is_query_q;
	logic                      hit_q;
	logic                      cmp_vld_q;
	logic [ict_pkg::CNT_W-1:0] scan_q;
	logic [ict_pkg::CNT_W-1:0] count_q;
	logic [ict_pkg::IDX_W-1:0] oldest_q;
	logic                      out_valid_q;
	ict_pkg::rsp_t             out_word_q;

	logic scan_more;
	logic full;
	logic can_finish;
	logic do_insert;
	logic key_match;

	assign scan_more  = scan_q < count_q;
	assign full       = count_q == ict_pkg::CNT_W'(ict_pkg::CAPACITY);
	assign can_finish = !out_valid_q || out_ready;
	assign do_insert  = (state_q == ST_UPDATE) && can_finish &&
		(is_query_q == ict_pkg::REQ_ADD) && !hit_q;
	assign key_match  = cmp_vld_q && (rd_data == key_q);

	always_comb begin
		mem_req       = '0;
		mem_req.re    = (state_q == ST_SCAN) && scan_more;
		mem_req.raddr = scan_q[ict_pkg::IDX_W-1:0];
		mem_req.we    = do_insert;
		mem_req.waddr = full ? oldest_q : count_q[ict_pkg::IDX_W-1:0];
		mem_req.wdata = key_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			is_query_q  <= 1'b0;
			hit_q       <= 1'b0;
			cmp_vld_q   <= 1'b0;
			scan_q      <= '0;
			count_q     <= '0;
			oldest_q    <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			key_q       <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_UPDATE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						key_q      <= {in_word.net_id, in_word.stream_id,
							in_word.service_id, in_word.pid};
						is_query_q <= in_word.req_type;
						hit_q      <= 1'b0;
						cmp_vld_q  <= 1'b0;
						scan_q     <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_vld_q <= scan_more;
					if (scan_more) begin
						scan_q <= scan_q + 1'b1;
					end
					if (key_match) begin
						hit_q <= 1'b1;
					end
					if (!scan_more && !cmp_vld_q) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (can_finish) begin
						out_valid_q     <= 1'b1;
						out_word_q.hit  <= hit_q;
						out_word_q.entry_count <= (do_insert && !full) ?
							ict_pkg::OUT_CNT_W'(count_q + 1'b1) :
							ict_pkg::OUT_CNT_W'(count_q);
						if (do_insert) begin
							if (full) begin
								oldest_q <= (oldest_q ==
									ict_pkg::IDX_W'(ict_pkg::CAPACITY - 1)) ?
									'0 : oldest_q + 1'b1;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

### hw/rtl/ignore_context_table.sv
// ignore context table: a fifo-replacement set of 64-bit stream context keys
// usage:
//   in channel (in_valid/in_ready/in_word) takes one request word: req_type
//   add or query, and the four 16-bit key fields net_id, stream_id,
//   service_id and pid
//   out channel (out_valid/out_ready/out_word) returns one word per request:
//   hit (key was held before the request) and entry_count after it
//   an add of an absent key stores it; once 32 keys are held the oldest one
//   is overwritten in arrival order; a present key keeps its age
//   after accept the single 64-bit comparator walks the held keys in the
//   key store one entry per cycle through its registered read port, then
//   the update step registers the result; a new request is not taken
//   until the sequencer is through with the last one
//   in_ready is high only while the sequencer is idle
//   a result waiting on a low out_ready does not block the next request's
//   scan; only its final update step waits for the output register to free
//   reset clears the count and oldest pointer, so the table is empty; the
//   key store itself is never cleared, entries past the count are not read
`timescale 1ns / 1ps

module ignore_context_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ict_pkg::req_t  in_word,
	output logic           out_valid,
	input  logic           out_ready,
	output ict_pkg::rsp_t  out_word
);

	ict_pkg::mem_req_t         mem_req;
	logic [ict_pkg::KEY_W-1:0] rd_data;

	ict_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	ict_key_mem u_key_mem (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

endmodule

### hw/rtl/ict_checker.sv
// port-level checker for the ignore context table, bound to the top level
`timescale 1ns / 1ps
`include "ignore_context_table_assert.svh"

module ict_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input ict_pkg::req_t in_word,
	input logic          out_valid,
	input logic          out_ready,
	input ict_pkg::rsp_t out_word
);

	logic in_acc;
	logic out_hold;

	assign in_acc   = in_valid && in_ready;
	assign out_hold = out_valid && !out_ready;

	`ICT_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(out_word))
	`ICT_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready)
	`ICT_ASSERT_NOW(a_hit_nonempty, out_valid && out_word.hit, out_word.entry_count != '0)
	`ICT_ASSERT_NEXT(a_no_result_on_accept, in_acc && !out_valid, !out_valid)

endmodule

bind ignore_context_table ict_checker u_ict_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);
